@@ rtl/core/object_table_coprocessor_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef OBJECT_TABLE_COPROCESSOR_CORE_ASSERT_SVH
`define OBJECT_TABLE_COPROCESSOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define OTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define OTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/otc_pkg.sv @@
package otc_pkg;

	localparam int ADDR_W    = 13;
	localparam int DATA_W    = 8;
	localparam int RAM_DEPTH = 1 << ADDR_W;
	localparam int INDEX_W   = 7;

	localparam logic [ADDR_W-1:0] BASE_LOW   = 13'h1800;
	localparam logic [ADDR_W-1:0] BASE_HIGH  = 13'h1C00;
	localparam logic [ADDR_W-1:0] ATTR_OFS   = 13'h0200;
	localparam logic [ADDR_W-1:0] WIN_REC0   = 13'h1FF0;
	localparam logic [ADDR_W-1:0] WIN_ATTR   = 13'h1FF4;
	localparam logic [ADDR_W-1:0] WIN_BASE   = 13'h1FF5;
	localparam logic [ADDR_W-1:0] WIN_INDEX  = 13'h1FF6;

	localparam logic [DATA_W-1:0]  FILL_BYTE   = 8'hFF;
	localparam logic [INDEX_W-1:0] INDEX_RESET = 7'h7F;
	localparam logic               BASE_RESET  = 1'b1;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} status_t;

endpackage

@@ rtl/core/otc_ram.sv @@
module otc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/otc_ctrl.sv @@
module otc_ctrl
	import otc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				done     = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/core/otc_dp.sv @@
module otc_dp
	import otc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic              mode,
	input  logic [ADDR_W-1:0] offset,
	input  logic [DATA_W-1:0] write_data,
	output logic [DATA_W-1:0] read_data
);

	logic [ADDR_W-1:0]  clr_cnt_q;
	logic               base_sel_q;
	logic [INDEX_W-1:0] index_q;
	logic               mode_q;
	logic               attr_q;
	logic [1:0]         field_q;
	logic [ADDR_W-1:0]  addr_q;

	logic [ADDR_W-1:0] table_base;
	logic [ADDR_W-1:0] rec_addr;
	logic [ADDR_W-1:0] attr_addr;
	logic              in_rec;
	logic              in_attr;
	logic [ADDR_W-1:0] acc_addr;
	logic [DATA_W-1:0] merged;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	assign table_base = base_sel_q ? BASE_LOW : BASE_HIGH;
	assign rec_addr   = table_base + {{(ADDR_W-INDEX_W-2){1'b0}}, index_q, offset[1:0]};
	assign attr_addr  = table_base + ATTR_OFS
		+ {{(ADDR_W-INDEX_W+2){1'b0}}, index_q[INDEX_W-1:2]};
	assign in_rec     = (offset[ADDR_W-1:2] == WIN_REC0[ADDR_W-1:2]);
	assign in_attr    = (offset == WIN_ATTR);

	always_comb begin
		if (in_rec) begin
			acc_addr = rec_addr;
		end else if (in_attr) begin
			acc_addr = attr_addr;
		end else begin
			acc_addr = offset;
		end
	end

	// replace only the selected 2-bit field of the attribute byte
	always_comb begin
		merged = ram_rdata;
		case (index_q[1:0])
			2'd0: merged[1:0] = field_q;
			2'd1: merged[3:2] = field_q;
			2'd2: merged[5:4] = field_q;
			2'd3: merged[7:6] = field_q;
			default: merged = ram_rdata;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = write_data;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_addr  = clr_cnt_q;
			ram_wdata = FILL_BYTE;
		end else if (cmd.accept) begin
			ram_addr = acc_addr;
			ram_we   = (mode == MODE_WRITE) && !in_attr;
		end else if (cmd.exec) begin
			ram_wdata = merged;
			ram_we    = (mode_q == MODE_WRITE) && attr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			base_sel_q <= BASE_RESET;
			index_q    <= INDEX_RESET;
			mode_q     <= MODE_READ;
			attr_q     <= 1'b0;
			field_q    <= '0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.accept) begin
				mode_q  <= mode;
				attr_q  <= in_attr;
				field_q <= write_data[1:0];
				if (mode == MODE_WRITE && offset == WIN_BASE) begin
					base_sel_q <= write_data[0];
				end
				if (mode == MODE_WRITE && offset == WIN_INDEX) begin
					index_q <= write_data[INDEX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= acc_addr;
		end
	end

	assign status.clear_last = (clr_cnt_q == {ADDR_W{1'b1}});
	assign read_data = (mode_q == MODE_WRITE) ? '0 : ram_rdata;

	otc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

endmodule

@@ rtl/core/object_table_coprocessor_core.sv @@
// Object attribute coprocessor, bus side.
// Command channel: raise start with mode, offset and write_data; the beat is
// taken at the rising edge where start is high and busy is low. busy rises in
// the following cycle and stays high until the result beat has gone.
// Result channel: done is high for exactly one cycle, the cycle right after
// the accepting edge; read_data then holds the byte read, or zero for a write.
// The receiver cannot hold results off. A new command beat is taken only
// after the result beat of the last one, set by the single-port work RAM
// with its registered read (the accepting cycle reads or writes, the next
// cycle presents the data or writes back the merged attribute byte).
// Reset: the FSM enters a clearing pass that writes 0xFF to all 8192 RAM
// bytes, one per cycle, after arst_n deasserts; busy stays high throughout.
// The table base comes up at 0x1800 and the object index at 0x7F.
module object_table_coprocessor_core
	import otc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [ADDR_W-1:0] offset,
	input  logic [DATA_W-1:0] write_data,
	output logic              done,
	output logic [DATA_W-1:0] read_data
);

	// command and status between the sequencer and the datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: clear pass, idle, execute/present
	otc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// datapath: window decode, table address, attribute merge, work RAM
	otc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (mode),
		.offset    (offset),
		.write_data(write_data),
		.read_data (read_data)
	);

endmodule

@@ rtl/core/otc_checker.sv @@
`include "object_table_coprocessor_core_assert.svh"

module otc_checker
	import otc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              mode,
	input logic              done,
	input logic [DATA_W-1:0] read_data
);

	`OTC_ASSERT_NEXT(a_accept_done, start && !busy, done, "no result beat after a command beat")
	`OTC_ASSERT_NOW(a_done_busy, done, busy, "result beat while not busy")
	`OTC_ASSERT_NOW(a_done_cause, done, $past(start && !busy), "result beat without a command beat")
	`OTC_ASSERT_NEXT(a_done_single, done, !done, "result beat repeated")
	`OTC_ASSERT_NOW(a_write_zero, done && $past(mode) == MODE_WRITE, read_data == '0, "write result not zero")

endmodule

bind object_table_coprocessor_core otc_checker u_otc_checker (.*);
